>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared widths, constants and types of the 3x3 edge-normalized box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int WID_BITS     = COL_BITS + 1;
    localparam int DIM_BITS     = 14;
    localparam int ROW_BITS     = 13;
    localparam int REG_BITS     = 13;

    localparam int CH_BITS    = 8;
    localparam int PIX_BITS   = 3 * CH_BITS;
    localparam int MEM_BITS   = 2 * PIX_BITS;
    localparam int SUM_BITS   = 12;
    localparam int RECIP_BITS = 14;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;

    // floor(x * R >> 16) equals x / n for every sum of up to nine channels
    localparam logic [RECIP_BITS-1:0] RECIP_6 = 14'd10923;
    localparam logic [RECIP_BITS-1:0] RECIP_9 = 14'd7282;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT   = FIFO_PTR + 1;

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } t_div;

    typedef struct packed {
        logic emit;
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } t_pos;

    typedef struct packed {
        logic                valid;
        logic                last;
        t_div                div;
        logic [SUM_BITS-1:0] sum_r;
        logic [SUM_BITS-1:0] sum_g;
        logic [SUM_BITS-1:0] sum_b;
    } t_sums;

    typedef struct packed {
        logic                last;
        logic [PIX_BITS-1:0] pix;
    } t_result;

endpackage

>>> rtl/bb3_line_mem.sv
// ----------------------------------------------------------------------------
// bb3_line_mem
// Both line stores in one memory, {upper, lower} per column, registered read.
// ----------------------------------------------------------------------------
module bb3_line_mem (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [bb3_pkg::COL_BITS-1:0]  i_rd_addr,
    output logic [bb3_pkg::MEM_BITS-1:0]  o_rd_data,
    input  logic                          i_wr_en,
    input  logic [bb3_pkg::COL_BITS-1:0]  i_wr_addr,
    input  logic [bb3_pkg::MEM_BITS-1:0]  i_wr_data
);
    import bb3_pkg::*;

    logic [MEM_BITS-1:0] r_mem [MAX_WIDTH];
    logic [MEM_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

>>> rtl/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 window shift and masked per-channel neighbor sums.
// ----------------------------------------------------------------------------
module bb3_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [bb3_pkg::PIX_BITS-1:0]  i_up,
    input  logic [bb3_pkg::PIX_BITS-1:0]  i_lo,
    input  logic [bb3_pkg::PIX_BITS-1:0]  i_px,
    input  bb3_pkg::t_pos                 i_pos,
    output bb3_pkg::t_sums                o_sums
);
    import bb3_pkg::*;

    logic [PIX_BITS-1:0] r_win [9];
    logic [PIX_BITS-1:0] n_win [9];
    logic [8:0]          use_tap;
    logic [SUM_BITS-1:0] sum_ch [3];
    t_sums               r_sums;
    t_sums               n_sums;

    always_comb begin
        for (int row = 0; row < 3; row++) begin
            n_win[row*3]     = r_win[row*3+1];
            n_win[row*3 + 1] = r_win[row*3+2];
        end
        n_win[2] = i_up;
        n_win[5] = i_lo;
        n_win[8] = i_px;

        for (int t = 0; t < 9; t++) begin
            use_tap[t] = !((t < 3 && !i_pos.top) || (t >= 6 && !i_pos.bot) ||
                           (t % 3 == 0 && !i_pos.left) || (t % 3 == 2 && !i_pos.right));
        end

        for (int ch = 0; ch < 3; ch++) begin
            sum_ch[ch] = '0;
            for (int t = 0; t < 9; t++) begin
                if (use_tap[t]) begin
                    sum_ch[ch] = sum_ch[ch] + SUM_BITS'(n_win[t][ch*CH_BITS +: CH_BITS]);
                end
            end
        end

        n_sums.valid = i_valid && i_pos.emit;
        n_sums.last  = i_pos.last;
        if (i_pos.top && i_pos.bot && i_pos.left && i_pos.right) begin
            n_sums.div = DIV_9;
        end else if ((i_pos.top && i_pos.bot) || (i_pos.left && i_pos.right)) begin
            n_sums.div = DIV_6;
        end else begin
            n_sums.div = DIV_4;
        end
        n_sums.sum_r = sum_ch[0];
        n_sums.sum_g = sum_ch[1];
        n_sums.sum_b = sum_ch[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int t = 0; t < 9; t++) begin
                r_win[t] <= n_win[t];
            end
        end
        if (!i_rst_n) begin
            r_sums.valid <= 1'b0;
        end else begin
            r_sums.valid <= n_sums.valid;
        end
        r_sums.last  <= n_sums.last;
        r_sums.div   <= n_sums.div;
        r_sums.sum_r <= n_sums.sum_r;
        r_sums.sum_g <= n_sums.sum_g;
        r_sums.sum_b <= n_sums.sum_b;
    end

    assign o_sums = r_sums;

endmodule

>>> rtl/bb3_mean.sv
// ----------------------------------------------------------------------------
// bb3_mean
// Truncated mean of each channel sum: by 4 as a shift, by 6 or 9 via reciprocals.
// ----------------------------------------------------------------------------
module bb3_mean (
    input  bb3_pkg::t_sums    i_sums,
    output logic              o_push,
    output bb3_pkg::t_result  o_result
);
    import bb3_pkg::*;

    function automatic logic [CH_BITS-1:0] f_mean(input logic [SUM_BITS-1:0] s,
                                                  input t_div d);
        logic [PROD_BITS-1:0] p;
        logic [CH_BITS-1:0]   m;
        p = '0;
        case (d)
            DIV_4: begin
                m = s[CH_BITS+1:2];
            end
            DIV_6: begin
                p = {{RECIP_BITS{1'b0}}, s} * {{SUM_BITS{1'b0}}, RECIP_6};
                m = p[16 +: CH_BITS];
            end
            DIV_9: begin
                p = {{RECIP_BITS{1'b0}}, s} * {{SUM_BITS{1'b0}}, RECIP_9};
                m = p[16 +: CH_BITS];
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

    assign o_push          = i_sums.valid;
    assign o_result.last   = i_sums.last;
    assign o_result.pix    = {f_mean(i_sums.sum_b, i_sums.div),
                              f_mean(i_sums.sum_g, i_sums.div),
                              f_mean(i_sums.sum_r, i_sums.div)};

endmodule

>>> rtl/bb3_out_fifo.sv
// ----------------------------------------------------------------------------
// bb3_out_fifo
// Small result queue that decouples the pipeline from the output receiver.
// ----------------------------------------------------------------------------
module bb3_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  bb3_pkg::t_result              i_data,
    output logic                          o_valid,
    output bb3_pkg::t_result              o_data,
    input  logic                          i_ready,
    output logic [bb3_pkg::FIFO_CNT-1:0]  o_count
);
    import bb3_pkg::*;

    t_result             r_buf [FIFO_DEPTH];
    logic [FIFO_PTR-1:0] r_wr;
    logic [FIFO_PTR-1:0] r_rd;
    logic [FIFO_CNT-1:0] r_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/box_blur_3x3_edge_normalized_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_top
// 3x3 box blur of an RGB raster stream, mean over in-image neighbors only.
// ----------------------------------------------------------------------------
// Pixels enter on the s channel in raster order; tuser marks a flush item,
// which counts as a zero pixel. Results leave on the m channel, tlast set on
// the last pixel of the frame. The result for pixel (r,c) is caused by the
// item carrying (r+1,c+1); after a frame the host sends width+1 flush items.
// One item per cycle is accepted while s tready is high; the result an item
// causes passes from the column read from the line memory through the window
// sum and divide into the output queue. The single-port-per-side line memory
// holds both line stores per column and is read and written once per item.
// The cfg channel is always ready; writing width or height restarts the
// frame position. Reset sets 640x480 and an empty pipeline. When the m
// receiver stalls, results collect in a four-entry queue and s tready drops
// once in-flight results would overflow it; no item is lost.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [23:0]                       i_s_tdata,  // red_in, green_in, blue_in
    input  logic                              i_s_tuser,  // is_flush
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [23:0]                       o_m_tdata,  // red_out, green_out, blue_out
    output logic                              o_m_tlast,  // frame_end
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bb3_pkg::REG_BITS-1:0]      i_cfg_data
);
    import bb3_pkg::*;

    logic [REG_BITS-1:0] r_width;
    logic [REG_BITS-1:0] r_height;
    logic [COL_BITS-1:0] r_col;
    logic [COL_BITS-1:0] n_col;
    logic [ROW_BITS-1:0] r_row;
    logic [ROW_BITS-1:0] n_row;

    logic                accept;
    logic                cfg_hit;
    logic [DIM_BITS-1:0] w_dim;
    logic [DIM_BITS-1:0] h_dim;
    logic [WID_BITS-1:0] w;
    logic [ROW_BITS-1:0] h;
    logic [WID_BITS-1:0] col_x;
    logic [WID_BITS-1:0] col_p1;
    logic [ROW_BITS-1:0] ctr_r;
    logic [WID_BITS-1:0] ctr_c;
    logic [WID_BITS-1:0] ctr_c_p1;
    logic [ROW_BITS:0]   ctr_r_p1;
    t_pos                pos;

    logic                r_a_valid;
    logic [PIX_BITS-1:0] r_a_px;
    logic [COL_BITS-1:0] r_a_col;
    t_pos                r_a_pos;
    logic [MEM_BITS-1:0] mem_q;

    t_sums               sums;
    logic                push;
    t_result             result;
    t_result             out_item;
    logic [FIFO_CNT-1:0] fifo_cnt;
    logic [FIFO_CNT:0]   pending;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);

    always_comb begin
        w_dim = {{(DIM_BITS-REG_BITS){1'b0}}, r_width};
        if (w_dim < DIM_BITS'(2)) begin
            w_dim = DIM_BITS'(2);
        end else if (w_dim > DIM_BITS'(MAX_WIDTH)) begin
            w_dim = DIM_BITS'(MAX_WIDTH);
        end
        h_dim = {{(DIM_BITS-REG_BITS){1'b0}}, r_height};
        if (h_dim < DIM_BITS'(2)) begin
            h_dim = DIM_BITS'(2);
        end else if (h_dim > DIM_BITS'(HEIGHT_LIMIT)) begin
            h_dim = DIM_BITS'(HEIGHT_LIMIT);
        end
        w = w_dim[WID_BITS-1:0];
        h = h_dim[ROW_BITS-1:0];
    end

    // center position one row and one pixel behind the incoming item
    always_comb begin
        col_x = {1'b0, r_col};
        col_p1 = col_x + 1'b1;
        if (r_col != '0) begin
            ctr_r = r_row - ROW_BITS'(1);
            ctr_c = col_x - 1'b1;
        end else begin
            ctr_r = r_row - ROW_BITS'(2);
            ctr_c = w - 1'b1;
        end
        ctr_c_p1 = ctr_c + 1'b1;
        ctr_r_p1 = {1'b0, ctr_r} + 1'b1;

        pos.emit  = (r_row >= ROW_BITS'(2)) || (r_row == ROW_BITS'(1) && r_col != '0);
        pos.top   = (ctr_r != '0);
        pos.bot   = (ctr_r_p1 != {1'b0, h});
        pos.left  = (ctr_c != '0);
        pos.right = (ctr_c_p1 != w);
        pos.last  = pos.emit && (ctr_r_p1 >= {1'b0, h}) && (ctr_c_p1 == w);

        if (pos.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_p1 >= w) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else begin
            n_col = col_p1[COL_BITS-1:0];
            n_row = r_row;
        end
    end

    // results in flight plus queued must fit the queue
    assign pending    = (FIFO_CNT+1)'(r_a_valid && r_a_pos.emit) + (FIFO_CNT+1)'(sums.valid)
                      + {1'b0, fifo_cnt};
    assign o_s_tready = (pending < (FIFO_CNT+1)'(FIFO_DEPTH));
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            if (cfg_hit) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
        if (accept) begin
            r_a_px  <= i_s_tuser ? '0 : i_s_tdata;
            r_a_col <= r_col;
            r_a_pos <= pos;
        end
    end

    bb3_line_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (mem_q),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_col),
        .i_wr_data ({mem_q[PIX_BITS-1:0], r_a_px})
    );

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .i_up    (mem_q[MEM_BITS-1:PIX_BITS]),
        .i_lo    (mem_q[PIX_BITS-1:0]),
        .i_px    (r_a_px),
        .i_pos   (r_a_pos),
        .o_sums  (sums)
    );

    bb3_mean u_mean (
        .i_sums   (sums),
        .o_push   (push),
        .o_result (result)
    );

    bb3_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_valid (o_m_tvalid),
        .o_data  (out_item),
        .i_ready (i_m_tready),
        .o_count (fifo_cnt)
    );

    assign o_m_tdata = out_item.pix;
    assign o_m_tlast = out_item.last;

endmodule
